@@ src/mlp_sigmoid_inference_macros.svh @@
// Assertion macros for the RTL file that checks its own sequencing.
`ifndef MLP_SIGMOID_INFERENCE_MACROS_SVH
`define MLP_SIGMOID_INFERENCE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSI_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/msi_pkg.sv @@
`default_nettype none

package msi_pkg;

	localparam int MAX_LAYERS = 4;
	localparam int MAX_WIDTH  = 16;

	localparam int W_DEPTH = (MAX_LAYERS - 1) * MAX_WIDTH * MAX_WIDTH;
	localparam int B_DEPTH = MAX_LAYERS * MAX_WIDTH;
	localparam int A_DEPTH = 2 * MAX_WIDTH;

	// Q13.24 sum of up to sixteen Q8.24 products of Q4.12 operands plus the scaled bias.
	localparam int ACC_W = 37;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_SIZE = 1'b1;

	typedef enum logic [1:0] {
		CMD_WEIGHT = 2'd0,
		CMD_BIAS   = 2'd1,
		CMD_INPUT  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		REG_LAYER_COUNT = 3'd0,
		REG_WIDTH_L0    = 3'd1,
		REG_WIDTH_L1    = 3'd2,
		REG_WIDTH_L2    = 3'd3,
		REG_WIDTH_L3    = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ERR,
		ST_BIAS,
		ST_MAC,
		ST_DRAIN,
		ST_ACT
	} state_t;

	typedef logic [12:0] sig_t;
	typedef sig_t sig_tab_t [256];

	// Entry i holds round(4096 / (1 + exp(-(i - 128) / 16))), worked out at elaboration.
	// The logistic function is written as (1 + tanh(x / 2)) / 2.
	function automatic sig_tab_t build_sig_table();
		sig_tab_t tab;
		real      v;
		for (int i = 0; i < 256; i++) begin
			v = 2048.0 * (1.0 + $tanh((real'(i) - 128.0) * 0.03125));
			tab[i] = 13'($rtoi(v + 0.5));
		end
		return tab;
	endfunction

	localparam sig_tab_t SIG_TABLE = build_sig_table();

	function automatic logic [4:0] clamp_width(input logic [4:0] v);
		logic [4:0] r;
		if (v == 5'd0) begin
			r = 5'd1;
		end else if (v > 5'(MAX_WIDTH)) begin
			r = 5'(MAX_WIDTH);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [2:0] clamp_layers(input logic [2:0] v);
		logic [2:0] r;
		if (v < 3'd2) begin
			r = 3'd2;
		end else if (v > 3'(MAX_LAYERS)) begin
			r = 3'(MAX_LAYERS);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ src/msi_ram.sv @@
`default_nettype none

module msi_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ src/mlp_sigmoid_inference.sv @@
// Forward pass of a fully connected network of two to four layers, up to sixteen
// neurons each, with a sigmoid after every layer but the input layer. Beats with
// tuser 0 or 1 load a weight or a bias; beats with tuser 2 deliver input
// elements, and the one with tlast set starts the pass. Beats are taken back to
// back while the block is idle. One shared 16x16 multiplier and accumulator does
// all the work: for each neuron it reads the bias, forms one product per input,
// lets the pipeline drain, then looks up the table and writes the result back or
// sends it out; the input side is not ready meanwhile. Results of the last layer
// leave in index order through an output register, and a stalled output holds
// the sequencer. If the number of input elements differs from width_layer0
// (clamped to 1..16), a single beat with tuser 1 and activation 0 is returned
// instead. Weights and biases must be loaded before a pass reads them.
`default_nettype none
`include "mlp_sigmoid_inference_macros.svh"

module mlp_sigmoid_inference (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// Commands and input elements
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // layer[1:0], row[5:2], column[9:6], value[25:10]
	input  wire logic [1:0]  s_axis_tuser,  // cmd[1:0]
	input  wire logic        s_axis_tlast,  // last
	// Results
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [23:0] m_axis_tdata,  // activation[12:0], index[16:13]
	output logic             m_axis_tuser,  // status
	output logic             m_axis_tlast   // final_res
);

	import msi_pkg::*;

	localparam int WA_W = $clog2(W_DEPTH);
	localparam int BA_W = $clog2(B_DEPTH);
	localparam int AA_W = $clog2(A_DEPTH);

	// Configuration registers
	logic [2:0] layer_count_q;
	logic [4:0] width_layer_q [MAX_LAYERS];
	logic [2:0] nl;
	logic [4:0] wcl [MAX_LAYERS];
	logic       cfg_we;

	// Sequencer
	state_t      state_q, state_d;
	logic [1:0]  layer_q;
	logic [3:0]  row_q;
	logic [3:0]  col_q;
	logic        src_q;
	logic [4:0]  in_count_q;
	logic [4:0]  count_inc;
	logic        size_bad;
	logic [3:0]  wprev_m1;
	logic [3:0]  wcur_m1;
	logic        last_layer;
	logic        row_done;

	// Input decode
	logic        s_acc;
	cmd_t        in_cmd;
	logic [1:0]  in_layer;
	logic [3:0]  in_row;
	logic [3:0]  in_col;
	logic [15:0] in_value;
	logic        in_elem;

	// Stores
	logic             w_we, b_we, a_we;
	logic [WA_W-1:0]  w_waddr, w_raddr;
	logic [BA_W-1:0]  b_waddr, b_raddr;
	logic [AA_W-1:0]  a_waddr, a_raddr;
	logic [15:0]      a_wdata;
	logic [15:0]      w_rdata, b_rdata, a_rdata;

	// Multiply-accumulate datapath
	logic                    bias_v_q;
	logic                    rd_v_s1;
	logic                    mul_v_s2;
	logic signed [31:0]      prod_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] rsum;
	logic [ACC_W-13:0]       rq;
	logic                    rq_fits;
	logic [7:0]              idx_d;
	logic [7:0]              idx_q;
	sig_t                    sig_val;

	// Output register
	logic        m_valid_q;
	logic [12:0] out_act_q;
	logic [3:0]  out_idx_q;
	logic        out_status_q;
	logic        out_final_q;
	logic        out_free;
	logic        out_load_ok;
	logic        out_load_err;

	// Configuration
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layer_count_q <= 3'd2;
			for (int i = 0; i < MAX_LAYERS; i++) begin
				width_layer_q[i] <= 5'd1;
			end
		end else if (cfg_we) begin
			case (reg_idx_t'(paddr[4:2]))
				REG_LAYER_COUNT: layer_count_q    <= pwdata[2:0];
				REG_WIDTH_L0:    width_layer_q[0] <= pwdata[4:0];
				REG_WIDTH_L1:    width_layer_q[1] <= pwdata[4:0];
				REG_WIDTH_L2:    width_layer_q[2] <= pwdata[4:0];
				REG_WIDTH_L3:    width_layer_q[3] <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[4:2]))
			REG_LAYER_COUNT: prdata = {29'd0, layer_count_q};
			REG_WIDTH_L0:    prdata = {27'd0, width_layer_q[0]};
			REG_WIDTH_L1:    prdata = {27'd0, width_layer_q[1]};
			REG_WIDTH_L2:    prdata = {27'd0, width_layer_q[2]};
			REG_WIDTH_L3:    prdata = {27'd0, width_layer_q[3]};
			default:         prdata = 32'd0;
		endcase
	end

	assign nl = clamp_layers(layer_count_q);
	always_comb begin
		for (int i = 0; i < MAX_LAYERS; i++) begin
			wcl[i] = clamp_width(width_layer_q[i]);
		end
	end

	// Input decode
	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc    = s_axis_tvalid && s_axis_tready;
	assign in_cmd   = cmd_t'(s_axis_tuser);
	assign in_layer = s_axis_tdata[1:0];
	assign in_row   = s_axis_tdata[5:2];
	assign in_col   = s_axis_tdata[9:6];
	assign in_value = s_axis_tdata[25:10];
	assign in_elem  = s_acc && (in_cmd == CMD_INPUT);

	assign count_inc = (in_count_q == 5'd31) ? 5'd31 : in_count_q + 5'd1;
	assign size_bad  = (count_inc != wcl[0]);

	// Layer geometry of the neuron in work
	assign wprev_m1   = 4'(wcl[layer_q - 2'd1] - 5'd1);
	assign wcur_m1    = 4'(wcl[layer_q] - 5'd1);
	assign last_layer = ({1'b0, layer_q} == nl - 3'd1);
	assign row_done   = (row_q == wcur_m1);

	assign out_free = !m_valid_q || m_axis_tready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_elem && s_axis_tlast) begin
					state_d = size_bad ? ST_ERR : ST_BIAS;
				end
			end
			ST_ERR: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_BIAS: state_d = ST_MAC;
			ST_MAC: begin
				if (col_q == wprev_m1) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!rd_v_s1 && !mul_v_s2) begin
					state_d = ST_ACT;
				end
			end
			ST_ACT: begin
				if (!last_layer || out_free) begin
					if (row_done && last_layer) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_BIAS;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: store ports and output register loads
	always_comb begin
		w_we         = 1'b0;
		b_we         = 1'b0;
		a_we         = 1'b0;
		w_waddr      = {in_layer - 2'd1, in_row, in_col};
		b_waddr      = {in_layer, in_row};
		a_waddr      = {1'b0, in_count_q[3:0]};
		a_wdata      = in_value;
		w_raddr      = {layer_q - 2'd1, row_q, col_q};
		b_raddr      = {layer_q, row_q};
		a_raddr      = {src_q, col_q};
		out_load_ok  = 1'b0;
		out_load_err = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					case (in_cmd)
						CMD_WEIGHT: w_we = (in_layer != 2'd0);
						CMD_BIAS:   b_we = (in_layer != 2'd0);
						CMD_INPUT:  a_we = (in_count_q < 5'(MAX_WIDTH));
						default: ;
					endcase
				end
			end
			ST_ERR: out_load_err = out_free;
			ST_ACT: begin
				if (last_layer) begin
					out_load_ok = out_free;
				end else begin
					a_we    = 1'b1;
					a_waddr = {~src_q, row_q};
					a_wdata = {3'd0, sig_val};
				end
			end
			default: ;
		endcase
	end

	// Counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			layer_q    <= 2'd1;
			row_q      <= 4'd0;
			col_q      <= 4'd0;
			src_q      <= 1'b0;
			in_count_q <= 5'd0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (in_elem) begin
						if (s_axis_tlast) begin
							in_count_q <= 5'd0;
							layer_q    <= 2'd1;
							row_q      <= 4'd0;
							src_q      <= 1'b0;
						end else begin
							in_count_q <= count_inc;
						end
					end
				end
				ST_BIAS: col_q <= 4'd0;
				ST_MAC:  col_q <= col_q + 4'd1;
				ST_ACT: begin
					if (!last_layer || out_free) begin
						if (row_done) begin
							row_q   <= 4'd0;
							layer_q <= layer_q + 2'd1;
							src_q   <= ~src_q;
						end else begin
							row_q <= row_q + 4'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	msi_ram #(.WIDTH(16), .DEPTH(W_DEPTH)) u_weight_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (in_value),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	msi_ram #(.WIDTH(16), .DEPTH(B_DEPTH)) u_bias_ram (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (in_value),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	msi_ram #(.WIDTH(16), .DEPTH(A_DEPTH)) u_act_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (a_wdata),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	// Pipeline flags: bias read valid, store read data valid, then product valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_v_q <= 1'b0;
			rd_v_s1  <= 1'b0;
			mul_v_s2 <= 1'b0;
		end else begin
			bias_v_q <= (state_q == ST_BIAS);
			rd_v_s1  <= (state_q == ST_MAC);
			mul_v_s2 <= rd_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_v_s1) begin
			prod_s2 <= $signed(w_rdata) * $signed(a_rdata);
		end
		if (bias_v_q) begin
			acc_q <= {{(ACC_W - 28){b_rdata[15]}}, b_rdata, 12'd0};
		end else if (mul_v_s2) begin
			acc_q <= acc_q + {{(ACC_W - 32){prod_s2[31]}}, prod_s2};
		end
		if (state_q == ST_DRAIN) begin
			idx_q <= idx_d;
		end
	end

	// Round half up to Q4.12, saturate, and keep the table index. The index is the
	// top byte with its sign flipped, so saturation lands on the table's ends.
	assign rsum    = acc_q + ACC_W'(2048);
	assign rq      = rsum[ACC_W-1:12];
	assign rq_fits = (&rq[ACC_W-13:15]) || !(|rq[ACC_W-13:15]);
	always_comb begin
		if (rq_fits) begin
			idx_d = {~rq[15], rq[14:8]};
		end else if (rq[ACC_W-13]) begin
			idx_d = 8'h00;
		end else begin
			idx_d = 8'hFF;
		end
	end

	assign sig_val = SIG_TABLE[idx_q];

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load_ok || out_load_err) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load_err) begin
			out_act_q    <= 13'd0;
			out_idx_q    <= 4'd0;
			out_status_q <= STATUS_SIZE;
			out_final_q  <= 1'b1;
		end else if (out_load_ok) begin
			out_act_q    <= sig_val;
			out_idx_q    <= row_q;
			out_status_q <= STATUS_OK;
			out_final_q  <= row_done;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'd0, out_idx_q, out_act_q};
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_final_q;

	`MSI_ASSERT_NEXT(a_size_err, in_elem && s_axis_tlast && size_bad, state_q == ST_ERR,
		"size mismatch did not lead to the error result")
	`MSI_ASSERT_SAME(a_mac_range, state_q == ST_MAC, {1'b0, col_q} <= {1'b0, wprev_m1},
		"product index ran past the previous layer")
	`MSI_ASSERT_SAME(a_drained, state_q == ST_ACT, !rd_v_s1 && !mul_v_s2 && !bias_v_q,
		"neuron finished while the accumulator pipeline was busy")
	`MSI_ASSERT_SAME(a_err_beat, m_axis_tvalid && m_axis_tuser,
		m_axis_tlast && (m_axis_tdata == 24'd0), "error beat carries data or is not final")

endmodule

`default_nettype wire
